### hw/rtl/sotd_pkg.sv
// Shared types and constants of the second-order tracking differentiator.
`default_nettype none

package sotd_pkg;

  localparam int unsigned Q_W        = 32;  // Q16.16 position and velocity
  localparam int unsigned COEF_W     = 31;  // omega, zeta, limit
  localparam int unsigned DT_W       = 32;  // Q0.32 time step
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MUL_OP_W   = 64;
  localparam int unsigned MUL_PROD_W = 96;
  localparam int unsigned ACC_W      = 61;  // signed, magnitude up to 2^60-1
  localparam int unsigned DIV_STEPS  = 32;

  localparam logic [59:0] ACC_MAX = 60'hFFF_FFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_NATURAL_FREQ   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_RATIO  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 8'd3;

  localparam logic [DT_W-1:0] TIME_STEP_RST = 32'd4294967;

  typedef enum logic [1:0] {
    MSH_Q15,
    MSH_Q16,
    MSH_Q32
  } mul_shift_e;

  typedef struct packed {
    logic [COEF_W-1:0] natural_freq;
    logic [COEF_W-1:0] damping_ratio;
    logic [COEF_W-1:0] velocity_limit;
    logic [DT_W-1:0]   time_step;
  } cfg_t;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_OP_W-1:0] a;
    logic signed [MUL_OP_W-1:0] b;
    mul_shift_e                 shift;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] num;
    logic [COEF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/sotd_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface sotd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sotd_pkg::CFG_IDX_W-1:0]   index;
  logic [sotd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/sotd_in_if.sv
// Input item channel.
`default_nettype none

interface sotd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [sotd_pkg::Q_W-1:0] value;
  logic signed [sotd_pkg::Q_W-1:0] start_velocity;

  modport source (output valid, output action, output value, output start_velocity,
                  input ready);
  modport sink   (input valid, input action, input value, input start_velocity,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/sotd_out_if.sv
// Result item channel.
`default_nettype none

interface sotd_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [sotd_pkg::Q_W-1:0] position;
  logic signed [sotd_pkg::Q_W-1:0] velocity;

  modport source (output valid, output position, output velocity, input ready);
  modport sink   (input valid, input position, input velocity, output ready);
endinterface

`default_nettype wire

### hw/rtl/sotd_regs.sv
// Configuration register file.
`default_nettype none

module sotd_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  sotd_cfg_if.sink         cfg_i,
  output sotd_pkg::cfg_t   cfg_o
);

  sotd_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.natural_freq   <= '0;
      cfg_q.damping_ratio  <= '0;
      cfg_q.velocity_limit <= '0;
      cfg_q.time_step      <= sotd_pkg::TIME_STEP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sotd_pkg::REG_NATURAL_FREQ:   cfg_q.natural_freq   <= cfg_i.data[sotd_pkg::COEF_W-1:0];
        sotd_pkg::REG_DAMPING_RATIO:  cfg_q.damping_ratio  <= cfg_i.data[sotd_pkg::COEF_W-1:0];
        sotd_pkg::REG_VELOCITY_LIMIT: cfg_q.velocity_limit <= cfg_i.data[sotd_pkg::COEF_W-1:0];
        sotd_pkg::REG_TIME_STEP:      cfg_q.time_step      <= cfg_i.data[sotd_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sotd_mul.sv
// Shared multiplier: four 32x32 partial products, then shift, saturate and sign.
`default_nettype none

module sotd_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sotd_pkg::mul_req_t  req_i,
  output sotd_pkg::mul_rsp_t  rsp_o
);

  logic                                  busy_q, fin_q, done_q;
  logic [1:0]                            step_q;
  logic [sotd_pkg::MUL_OP_W-1:0]         a_q, b_q;
  logic                                  neg_q;
  sotd_pkg::mul_shift_e                  sh_q;
  logic [sotd_pkg::MUL_PROD_W-1:0]       prod_q;
  logic signed [sotd_pkg::ACC_W-1:0]     res_q;

  logic [sotd_pkg::MUL_OP_W-1:0]         a_abs, b_abs;
  logic [31:0]                           a_limb, b_limb;
  logic [63:0]                           pp;
  logic [sotd_pkg::MUL_PROD_W-1:0]       pp_sh, shifted;
  logic [59:0]                           mag;
  logic [sotd_pkg::ACC_W-1:0]            mag_ext;

  assign a_abs  = req_i.a[sotd_pkg::MUL_OP_W-1] ? -req_i.a : req_i.a;
  assign b_abs  = req_i.b[sotd_pkg::MUL_OP_W-1] ? -req_i.b : req_i.b;
  assign a_limb = step_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_limb = step_q[0] ? b_q[63:32] : b_q[31:0];
  assign pp     = a_limb * b_limb;

  always_comb begin
    unique case ({1'b0, step_q[1]} + {1'b0, step_q[0]})
      2'd0:    pp_sh = {32'd0, pp};
      2'd1:    pp_sh = {pp, 32'd0};
      2'd2:    pp_sh = {pp[31:0], 64'd0};
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    unique case (sh_q)
      sotd_pkg::MSH_Q15: shifted = prod_q >> 15;
      sotd_pkg::MSH_Q16: shifted = prod_q >> 16;
      sotd_pkg::MSH_Q32: shifted = prod_q >> 32;
      default:           shifted = prod_q;
    endcase
  end

  assign mag     = (|shifted[sotd_pkg::MUL_PROD_W-1:60]) ? sotd_pkg::ACC_MAX : shifted[59:0];
  assign mag_ext = {1'b0, mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q    <= a_abs;
      b_q    <= b_abs;
      neg_q  <= req_i.a[sotd_pkg::MUL_OP_W-1] ^ req_i.b[sotd_pkg::MUL_OP_W-1];
      sh_q   <= req_i.shift;
      prod_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_q + pp_sh;
    end else if (fin_q) begin
      res_q  <= $signed(neg_q ? (~mag_ext + 61'd1) : mag_ext);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (!busy_q && !fin_q))
    else $error("multiplier restarted while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held");

endmodule

`default_nettype wire

### hw/rtl/sotd_div.sv
// Fractional divider: floor(num * 2^31 / den) for num <= den, one bit per cycle.
`default_nettype none

module sotd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sotd_pkg::div_req_t  req_i,
  output sotd_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CNT_W = $clog2(sotd_pkg::DIV_STEPS);

  logic                              busy_q, done_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic [31:0]                       r_q;
  logic [sotd_pkg::COEF_W-1:0]       den_q;
  logic [sotd_pkg::DIV_STEPS-1:0]    q_q;

  logic [31:0]                       tr, r_n;
  logic                              ge;

  assign tr  = (cnt_q == '0) ? r_q : {r_q[30:0], 1'b0};
  assign ge  = tr >= {1'b0, den_q};
  assign r_n = ge ? (tr - {1'b0, den_q}) : tr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(sotd_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= {1'b0, req_i.num};
      den_q <= req_i.den;
      q_q   <= '0;
    end else if (busy_q) begin
      r_q <= r_n;
      q_q <= {q_q[sotd_pkg::DIV_STEPS-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = q_q;

endmodule

`default_nettype wire

### hw/rtl/sotd_core.sv
// Step sequencer: holds position and velocity, drives the multiplier and divider.
`default_nettype none

module sotd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  sotd_in_if.sink             in_i,
  sotd_out_if.source          out_o,
  input  sotd_pkg::cfg_t      cfg_i,
  output sotd_pkg::mul_req_t  mul_req_o,
  input  sotd_pkg::mul_rsp_t  mul_rsp_i,
  output sotd_pkg::div_req_t  div_req_o,
  input  sotd_pkg::div_rsp_t  div_rsp_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_W2    = 5'd1;
  localparam logic [4:0] S_ZW    = 5'd2;
  localparam logic [4:0] S_P1    = 5'd3;
  localparam logic [4:0] S_P2    = 5'd4;
  localparam logic [4:0] S_ACC   = 5'd5;
  localparam logic [4:0] S_PRED  = 5'd6;
  localparam logic [4:0] S_ABS   = 5'd7;
  localparam logic [4:0] S_TEN   = 5'd8;
  localparam logic [4:0] S_EXC   = 5'd9;
  localparam logic [4:0] S_CHK   = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_SOFT  = 5'd12;
  localparam logic [4:0] S_VST   = 5'd13;
  localparam logic [4:0] S_VEL   = 5'd14;
  localparam logic [4:0] S_CLAMP = 5'd15;
  localparam logic [4:0] S_PST   = 5'd16;
  localparam logic [4:0] S_POS   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  logic [4:0]               state_q, state_d;
  logic signed [31:0]       pos_q, pos_d, vel_q, vel_d, tgt_q, tgt_d;
  logic [47:0]              w2_q, w2_d, zw2_q, zw2_d;
  logic signed [60:0]       t_q, t_d, acc_q, acc_d;
  logic signed [61:0]       pred_q, pred_d;
  logic signed [65:0]       wk_q, wk_d;
  logic [34:0]              lim9_q, lim9_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [31:0]       out_pos_q, out_pos_d, out_vel_q, out_vel_d;

  logic signed [60:0]       mres;
  logic signed [32:0]       err;
  logic signed [61:0]       diff, vsum, psum, pabs;
  logic signed [61:0]       acc_hi, acc_lo, lim_hi, lim_lo, q_hi, q_lo;
  logic [30:0]              lim;
  logic                     lim_nz;
  logic signed [65:0]       lim_wide;
  logic [31:0]              dt;

  assign mres     = mul_rsp_i.res;
  assign lim      = cfg_i.velocity_limit;
  assign lim_nz   = (lim != '0);
  assign dt       = cfg_i.time_step;
  assign err      = {tgt_q[31], tgt_q} - {pos_q[31], pos_q};
  assign diff     = {t_q[60], t_q} - {mres[60], mres};
  assign vsum     = {{30{vel_q[31]}}, vel_q} + {mres[60], mres};
  assign psum     = {{30{pos_q[31]}}, pos_q} + {mres[60], mres};
  assign pabs     = pred_q[61] ? -pred_q : pred_q;
  assign acc_hi   = $signed({2'b00, sotd_pkg::ACC_MAX});
  assign acc_lo   = -acc_hi;
  assign lim_hi   = $signed({31'd0, lim});
  assign lim_lo   = -lim_hi;
  assign q_hi     = 62'sd2147483647;
  assign q_lo     = -62'sd2147483648;
  assign lim_wide = $signed({35'd0, lim});

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    tgt_d       = tgt_q;
    w2_d        = w2_q;
    zw2_d       = zw2_q;
    t_d         = t_q;
    acc_d       = acc_q;
    pred_d      = pred_q;
    wk_d        = wk_q;
    lim9_d      = lim9_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_pos_d   = out_pos_q;
    out_vel_d   = out_vel_q;
    mul_req_o   = '0;
    div_req_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.action) begin
            pos_d   = in_i.value;
            vel_d   = in_i.start_velocity;
            state_d = S_OUT;
          end else begin
            tgt_d           = in_i.value;
            mul_req_o.start = 1'b1;
            mul_req_o.a     = $signed({33'd0, cfg_i.natural_freq});
            mul_req_o.b     = $signed({33'd0, cfg_i.natural_freq});
            mul_req_o.shift = sotd_pkg::MSH_Q16;
            state_d         = S_W2;
          end
        end
      end
      S_W2: begin
        if (mul_rsp_i.done) begin
          w2_d            = mres[47:0];
          mul_req_o.start = 1'b1;
          mul_req_o.a     = $signed({33'd0, cfg_i.damping_ratio});
          mul_req_o.b     = $signed({33'd0, cfg_i.natural_freq});
          mul_req_o.shift = sotd_pkg::MSH_Q15;
          state_d         = S_ZW;
        end
      end
      S_ZW: begin
        if (mul_rsp_i.done) begin
          zw2_d           = mres[47:0];
          mul_req_o.start = 1'b1;
          mul_req_o.a     = $signed({16'd0, w2_q});
          mul_req_o.b     = {{31{err[32]}}, err};
          mul_req_o.shift = sotd_pkg::MSH_Q16;
          state_d         = S_P1;
        end
      end
      S_P1: begin
        if (mul_rsp_i.done) begin
          t_d             = mres;
          mul_req_o.start = 1'b1;
          mul_req_o.a     = $signed({16'd0, zw2_q});
          mul_req_o.b     = {{32{vel_q[31]}}, vel_q};
          mul_req_o.shift = sotd_pkg::MSH_Q16;
          state_d         = S_P2;
        end
      end
      S_P2: begin
        if (mul_rsp_i.done) begin
          if (diff > acc_hi) begin
            acc_d = acc_hi[60:0];
          end else if (diff < acc_lo) begin
            acc_d = acc_lo[60:0];
          end else begin
            acc_d = diff[60:0];
          end
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = {{3{acc_q[60]}}, acc_q};
        mul_req_o.b     = $signed({32'd0, dt});
        mul_req_o.shift = sotd_pkg::MSH_Q32;
        state_d         = lim_nz ? S_PRED : S_VEL;
      end
      S_PRED: begin
        if (mul_rsp_i.done) begin
          pred_d  = vsum;
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        wk_d    = {4'd0, pabs};
        lim9_d  = {1'b0, lim, 3'b000} + {4'd0, lim};
        state_d = S_TEN;
      end
      S_TEN: begin
        wk_d    = (wk_q <<< 3) + (wk_q <<< 1);
        state_d = S_EXC;
      end
      S_EXC: begin
        wk_d    = wk_q - $signed({31'd0, lim9_q});
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!wk_q[65] && (wk_q != '0)) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = (wk_q > lim_wide) ? lim : wk_q[30:0];
          div_req_o.den   = lim;
          state_d         = S_DIV;
        end else begin
          state_d = S_CLAMP;
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          mul_req_o.start = 1'b1;
          mul_req_o.a     = {{3{acc_q[60]}}, acc_q};
          mul_req_o.b     = $signed({32'd0, div_rsp_i.quo});
          mul_req_o.shift = sotd_pkg::MSH_Q32;
          state_d         = S_SOFT;
        end
      end
      S_SOFT: begin
        if (mul_rsp_i.done) begin
          acc_d   = acc_q - mres;
          state_d = S_VST;
        end
      end
      S_VST: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = {{3{acc_q[60]}}, acc_q};
        mul_req_o.b     = $signed({32'd0, dt});
        mul_req_o.shift = sotd_pkg::MSH_Q32;
        state_d         = S_VEL;
      end
      S_VEL: begin
        if (mul_rsp_i.done) begin
          pred_d  = vsum;
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (lim_nz) begin
          if (pred_q > lim_hi) begin
            vel_d = lim_hi[31:0];
          end else if (pred_q < lim_lo) begin
            vel_d = lim_lo[31:0];
          end else begin
            vel_d = pred_q[31:0];
          end
        end else begin
          if (pred_q > q_hi) begin
            vel_d = q_hi[31:0];
          end else if (pred_q < q_lo) begin
            vel_d = q_lo[31:0];
          end else begin
            vel_d = pred_q[31:0];
          end
        end
        state_d = S_PST;
      end
      S_PST: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = {{32{vel_q[31]}}, vel_q};
        mul_req_o.b     = $signed({32'd0, dt});
        mul_req_o.shift = sotd_pkg::MSH_Q32;
        state_d         = S_POS;
      end
      S_POS: begin
        if (mul_rsp_i.done) begin
          if (psum > q_hi) begin
            pos_d = q_hi[31:0];
          end else if (psum < q_lo) begin
            pos_d = q_lo[31:0];
          end else begin
            pos_d = psum[31:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          out_vel_d   = vel_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    w2_q      <= w2_d;
    zw2_q     <= zw2_d;
    t_q       <= t_d;
    acc_q     <= acc_d;
    pred_q    <= pred_d;
    wk_q      <= wk_d;
    lim9_q    <= lim9_d;
    out_pos_q <= out_pos_d;
    out_vel_q <= out_vel_d;
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.position = out_pos_q;
  assign out_o.velocity = out_vel_q;

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> (state_q == S_W2 || state_q == S_ZW || state_q == S_P1 ||
                        state_q == S_P2 || state_q == S_PRED || state_q == S_SOFT ||
                        state_q == S_VEL || state_q == S_POS))
    else $error("multiplier result arrived outside a wait state");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == S_DIV))
    else $error("divider result arrived outside its wait state");

  a_vel_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PST && lim_nz) |->
      ($signed({vel_q[31], vel_q}) <= $signed({2'b00, lim}) &&
       $signed({vel_q[31], vel_q}) >= -$signed({2'b00, lim})))
    else $error("velocity outside its limit after clamp");

endmodule

`default_nettype wire

### hw/rtl/second_order_tracking_differentiator.sv
// Top level: second-order tracking differentiator in Q16.16.
// A load item's result is registered in S_OUT once the output can take it.
// An update's result waits on the shared multiplier for each product and, with a velocity
// limit, when the soft limit engages, also on the 32-step soft-limit divider;
// one item is in work at a time. Reset clears position and velocity, zeroes the
// coefficient registers and sets the time step to TIME_STEP_RST.
`default_nettype none

module second_order_tracking_differentiator (
  input  logic         clk_i,
  input  logic         rst_ni,
  sotd_cfg_if.sink     cfg_i,
  sotd_in_if.sink      in_i,
  sotd_out_if.source   out_o
);

  sotd_pkg::cfg_t      cfg;
  sotd_pkg::mul_req_t  mul_req;
  sotd_pkg::mul_rsp_t  mul_rsp;
  sotd_pkg::div_req_t  div_req;
  sotd_pkg::div_rsp_t  div_rsp;

  sotd_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sotd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  sotd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sotd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .cfg_i     (cfg),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the second-order tracking differentiator.

module testbench;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  localparam logic [sotd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
  localparam logic [sotd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  localparam longint ACC_LIM     = longint'(sotd_pkg::ACC_MAX);
  localparam longint Q_HI        = 64'sh7FFF_FFFF;
  localparam longint Q_LO        = -64'sh8000_0000;
  localparam int     STALL_LIMIT = 5000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     DRAIN_CYCLES = 120;
  localparam int     PHASES      = 9;
  localparam int     PHASE_ITEMS = 150;

  typedef struct packed {
    logic signed [sotd_pkg::Q_W-1:0] position;
    logic signed [sotd_pkg::Q_W-1:0] velocity;
  } track_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        action;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
    logic        known;
    logic [31:0] want_pos;
    logic [31:0] want_vel;
  } step_row_t;

  logic clk_i;
  logic rst_ni;

  sotd_cfg_if cfg_if ();
  sotd_in_if  in_if ();
  sotd_out_if out_if ();

  second_order_tracking_differentiator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the block's registers and state
  logic [sotd_pkg::COEF_W-1:0] cfg_nf  = '0;
  logic [sotd_pkg::COEF_W-1:0] cfg_zr  = '0;
  logic [sotd_pkg::COEF_W-1:0] cfg_lim = '0;
  logic [sotd_pkg::DT_W-1:0]   cfg_dt  = sotd_pkg::TIME_STEP_RST;
  longint                      trk_pos = 0;
  longint                      trk_vel = 0;

  track_t pending_states [$];

  // typed-in expectation travelling with the item
  logic        known_tag = 1'b0;
  logic [31:0] known_pos = '0;
  logic [31:0] known_vel = '0;

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int          tx_idle_pct   = 23;
  int          rx_idle_pct   = 23;
  int          hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sign(a*b) * min(|a|*|b| >> sh, 2^60-1)
  function automatic longint scaled_product(input longint a, input longint b,
                                            input int unsigned sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  m;
    logic [127:0] full;
    ua   = (a < 0) ? 64'(-a) : 64'(a);
    ub   = (b < 0) ? 64'(-b) : 64'(b);
    full = ({64'd0, ua} * {64'd0, ub}) >> sh;
    m    = (full[127:60] != '0) ? 64'(ACC_LIM) : full[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint bound(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic track_t track_step(input logic act, input logic signed [31:0] val,
                                        input logic signed [31:0] vel_in);
    longint          dt;
    longint          lim;
    longint          w2;
    longint          zw2;
    longint          acc;
    longint          nv;
    longint unsigned speed;
    longint unsigned excess;
    longint unsigned frac;
    track_t          r;
    if (act == ACT_LOAD) begin
      trk_pos = longint'(val);
      trk_vel = longint'(vel_in);
    end else begin
      dt  = longint'({32'd0, cfg_dt});
      lim = longint'({33'd0, cfg_lim});
      w2  = longint'(({33'd0, cfg_nf} * {33'd0, cfg_nf}) >> 16);
      zw2 = longint'(({33'd0, cfg_zr} * {33'd0, cfg_nf} * 64'd2) >> 16);
      acc = scaled_product(w2, longint'(val) - trk_pos, 16)
          - scaled_product(zw2, trk_vel, 16);
      acc = bound(acc, -ACC_LIM, ACC_LIM);
      if (lim > 0) begin
        nv    = trk_vel + scaled_product(acc, dt, 32);
        speed = (nv < 0) ? -nv : nv;
        if (speed * 10 > lim * 9) begin
          excess = speed * 10 - lim * 9;
          if (excess > lim) excess = lim;
          frac = (excess << 31) / lim;
          acc  = acc - scaled_product(acc, longint'(frac), 32);
        end
        nv = bound(trk_vel + scaled_product(acc, dt, 32), -lim, lim);
      end else begin
        nv = bound(trk_vel + scaled_product(acc, dt, 32), Q_LO, Q_HI);
      end
      trk_vel = nv;
      trk_pos = bound(trk_pos + scaled_product(nv, dt, 32), Q_LO, Q_HI);
    end
    r.position = trk_pos[31:0];
    r.velocity = trk_vel[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : track_monitor
    track_t want;
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        sotd_pkg::REG_NATURAL_FREQ:   cfg_nf  = cfg_if.data[sotd_pkg::COEF_W-1:0];
        sotd_pkg::REG_DAMPING_RATIO:  cfg_zr  = cfg_if.data[sotd_pkg::COEF_W-1:0];
        sotd_pkg::REG_VELOCITY_LIMIT: cfg_lim = cfg_if.data[sotd_pkg::COEF_W-1:0];
        sotd_pkg::REG_TIME_STEP:      cfg_dt  = cfg_if.data;
        default: ;
      endcase
    end
    if (in_if.valid && in_if.ready) begin
      want = track_step(in_if.action, in_if.value, in_if.start_velocity);
      if (known_tag) begin
        want.position = known_pos;
        want.velocity = known_vel;
      end
      pending_states.push_back(want);
    end
    if (out_if.valid && out_if.ready) begin
      if (pending_states.size() == 0) begin
        report_mismatch("unexpected item, position", out_if.position, '0);
      end else begin
        want = pending_states.pop_front();
        if (out_if.position !== want.position)
          report_mismatch("position", out_if.position, want.position);
        if (out_if.velocity !== want.velocity)
          report_mismatch("velocity", out_if.velocity, want.velocity);
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int stall_count;
    stall_count = 0;
    while (stall_count < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_count = 0;
      else
        stall_count++;
    end
    $display("** second_order_tracking_differentiator: FAILED **");
    $finish;
  end

  task automatic write_reg(input logic [sotd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  task automatic send_item(input logic act, input logic [31:0] val, input logic [31:0] vel,
                           input logic known, input logic [31:0] kpos,
                           input logic [31:0] kvel);
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.action         <= act;
    in_if.value          <= val;
    in_if.start_velocity <= vel;
    known_tag            <= known;
    known_pos            <= kpos;
    known_vel            <= kvel;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic step_row_t item_row(input logic act, input logic [31:0] a,
                                         input logic [31:0] b);
    return '{ROW_ITEM, act, a, b, 1'b0, 32'h0, 32'h0};
  endfunction

  function automatic step_row_t known_row(input logic act, input logic [31:0] a,
                                          input logic [31:0] b, input logic [31:0] p,
                                          input logic [31:0] v);
    return '{ROW_ITEM, act, a, b, 1'b1, p, v};
  endfunction

  function automatic step_row_t write_row(input logic [sotd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] data);
    return '{ROW_WRITE, ACT_UPDATE, 32'(idx), data, 1'b0, 32'h0, 32'h0};
  endfunction

  function automatic logic [31:0] pick_field(input logic [31:0] floor_v,
                                             input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(5))
      0:       return floor_v;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
    endcase
  endfunction

  initial begin : stimulus
    step_row_t   plan [$];
    int          run_left;
    int          roll;
    logic [31:0] target;

    rst_ni = 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    in_if.valid          <= 1'b0;
    in_if.action         <= ACT_UPDATE;
    in_if.value          <= '0;
    in_if.start_velocity <= '0;

    // reset settings: no gain, so updates keep the velocity; a state at rest stays at rest
    plan.push_back(known_row(ACT_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0));
    plan.push_back(known_row(ACT_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    plan.push_back(known_row(ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(item_row(ACT_UPDATE, 32'h0, 32'h0));
    plan.push_back(known_row(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(item_row(ACT_UPDATE, 32'h7FFF_FFFF, 32'h0));
    // top bit of the coefficients is masked off; full-scale step saturates
    plan.push_back(write_row(sotd_pkg::REG_NATURAL_FREQ, 32'hFFFF_FFFF));
    plan.push_back(write_row(sotd_pkg::REG_DAMPING_RATIO, 32'h0001_0000));
    plan.push_back(write_row(sotd_pkg::REG_TIME_STEP, 32'hFFFF_FFFF));
    plan.push_back(known_row(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0));
    plan.push_back(item_row(ACT_UPDATE, 32'h7FFF_FFFF, 32'h0));
    plan.push_back(item_row(ACT_UPDATE, 32'h8000_0000, 32'h0));
    plan.push_back(item_row(ACT_UPDATE, 32'h8000_0000, 32'h0));
    // soft velocity limit
    plan.push_back(write_row(sotd_pkg::REG_NATURAL_FREQ, 32'h0002_0000));
    plan.push_back(write_row(sotd_pkg::REG_DAMPING_RATIO, 32'h0000_B505));
    plan.push_back(write_row(sotd_pkg::REG_VELOCITY_LIMIT, 32'h0001_0000));
    plan.push_back(write_row(sotd_pkg::REG_TIME_STEP, 32'h0100_0000));
    plan.push_back(known_row(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0));
    repeat (4) plan.push_back(item_row(ACT_UPDATE, 32'h0010_0000, 32'h0));
    plan.push_back(known_row(ACT_LOAD, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
    plan.push_back(item_row(ACT_UPDATE, 32'h0, 32'h0));
    // zero time step: position holds, velocity still clamped to the limit
    plan.push_back(write_row(sotd_pkg::REG_TIME_STEP, 32'h0));
    plan.push_back(known_row(ACT_LOAD, 32'h1234_5678, 32'h7FFF_FFFF,
                             32'h1234_5678, 32'h7FFF_FFFF));
    plan.push_back(known_row(ACT_UPDATE, 32'h7FFF_FFFF, 32'h0,
                             32'h1234_5678, 32'h0001_0000));
    plan.push_back(known_row(ACT_LOAD, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000));
    plan.push_back(known_row(ACT_UPDATE, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_0000));
    // unmapped writes are dropped; largest gains, smallest step
    plan.push_back(write_row(REG_UNMAPPED_LO, 32'h0));
    plan.push_back(write_row(REG_UNMAPPED_HI, 32'hFFFF_FFFF));
    plan.push_back(write_row(sotd_pkg::REG_NATURAL_FREQ, 32'h7FFF_FFFF));
    plan.push_back(write_row(sotd_pkg::REG_DAMPING_RATIO, 32'h7FFF_FFFF));
    plan.push_back(write_row(sotd_pkg::REG_VELOCITY_LIMIT, 32'h7FFF_FFFF));
    plan.push_back(write_row(sotd_pkg::REG_TIME_STEP, 32'h1));
    plan.push_back(known_row(ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(item_row(ACT_UPDATE, 32'h8000_0000, 32'h0));
    plan.push_back(item_row(ACT_UPDATE, 32'h7FFF_FFFF, 32'h0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].arg_a[sotd_pkg::CFG_IDX_W-1:0], plan[i].arg_b);
      end else begin
        send_item(plan[i].action, plan[i].arg_a, plan[i].arg_b, plan[i].known,
                  plan[i].want_pos, plan[i].want_vel);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      tx_idle_pct = (ph == 3) ? 0 : 23;
      rx_idle_pct = (ph == 3) ? 0 : 23;
      case (ph)
        0: begin
          write_reg(sotd_pkg::REG_NATURAL_FREQ, 32'h7FFF_FFFF);
          write_reg(sotd_pkg::REG_DAMPING_RATIO, 32'h7FFF_FFFF);
          write_reg(sotd_pkg::REG_VELOCITY_LIMIT, 32'h7FFF_FFFF);
          write_reg(sotd_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(sotd_pkg::REG_NATURAL_FREQ, 32'h0);
          write_reg(sotd_pkg::REG_DAMPING_RATIO, 32'h0);
          write_reg(sotd_pkg::REG_VELOCITY_LIMIT, 32'h0);
          write_reg(sotd_pkg::REG_TIME_STEP, 32'h1);
        end
        default: begin
          write_reg(sotd_pkg::REG_NATURAL_FREQ,
                    pick_field(32'h0, 32'h0000_4000, 32'h0040_0000));
          write_reg(sotd_pkg::REG_DAMPING_RATIO,
                    pick_field(32'h0, 32'h0000_2000, 32'h0003_0000));
          write_reg(sotd_pkg::REG_VELOCITY_LIMIT,
                    pick_field(32'h0, 32'h0000_1000, 32'h0100_0000));
          write_reg(sotd_pkg::REG_TIME_STEP,
                    pick_field(32'h1, 32'h0004_0000, 32'h0400_0000));
        end
      endcase
      if ($urandom_range(2) == 0)
        write_reg(sotd_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                  $urandom);
      if (ph == 5) hold_requests <= hold_requests + 1;

      run_left = 0;
      target   = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          send_item(ACT_LOAD, $urandom, $urandom, 1'b0, '0, '0);
        end else if (roll < 12) begin
          send_item(1'($urandom_range(1)), $urandom, $urandom, 1'b0, '0, '0);
        end else begin
          if (run_left == 0) begin
            target   = pick_target();
            run_left = $urandom_range(40, 3);
          end
          run_left--;
          send_item(ACT_UPDATE, target, $urandom, 1'b0, '0, '0);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_states.size() == 0)
      $display("** second_order_tracking_differentiator: PASSED **");
    else
      $display("** second_order_tracking_differentiator: FAILED **");
    $finish;
  end

endmodule
